FILE: hw/rtl/seq_receive_window_dedup_assert.svh
// Assertion macros used by the receive window RTL.
`ifndef SEQ_RECEIVE_WINDOW_DEDUP_ASSERT_SVH
`define SEQ_RECEIVE_WINDOW_DEDUP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SRWD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SRWD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hw/rtl/srwd_pkg.sv
// Types and constants of the per-peer receive window.
package srwd_pkg;

   localparam int SeqW      = 16;
   localparam int PeerW     = 4;
   localparam int PeerSpan  = 16;
   localparam int HistOutW  = 32;
   localparam int VerdictW  = 2;

   localparam logic KIND_RECV  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [VerdictW-1:0] VERDICT_ACCEPT  = 2'd0;
   localparam logic [VerdictW-1:0] VERDICT_DUP     = 2'd1;
   localparam logic [VerdictW-1:0] VERDICT_TOO_OLD = 2'd2;
   localparam logic [VerdictW-1:0] VERDICT_UNUSED  = 2'd3;

   typedef struct packed {
      logic            kind;
      logic [PeerW-1:0] peer;
      logic [SeqW-1:0]  seq;
   } req_type;

   typedef struct packed {
      logic [VerdictW-1:0] verdict;
      logic                ack_valid;
      logic [SeqW-1:0]     ack_seq;
      logic [HistOutW-1:0] ack_history;
   } rsp_type;

endpackage

FILE: hw/rtl/seq_receive_window_dedup.sv
// Top level: per-peer receive window with duplicate and age filtering.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------
//   req     | in        | req_valid / req_ready  | srwd_pkg::req_type
//   rsp     | out       | rsp_valid / rsp_ready  | srwd_pkg::rsp_type
//
// One transaction per cycle sustained while rsp is not stalled; a result is
// registered on rsp once its request has passed the stages (read, then update).
// The per-peer read-modify-write on the window memory sets the rate; a write
// to the same peer as the following request is forwarded, so no bubble.
// seen_ff lives in flip-flops that reset clears at once: no clearing pass.
// A stall on rsp holds the update stage, which in turn drops req_ready.
// Reset is synchronous and active high.
module seq_receive_window_dedup #(
   parameter int PEERS  = 16,
   parameter int WINDOW = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  srwd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output srwd_pkg::rsp_type rsp_data
);

   // Only peers reachable through the 4-bit peer field get storage.
   localparam int DEPTH = (PEERS < srwd_pkg::PeerSpan) ? PEERS : srwd_pkg::PeerSpan;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW    = $clog2(WINDOW);
   localparam int EW    = srwd_pkg::SeqW + WINDOW;
   localparam logic [srwd_pkg::SeqW-1:0] WinSeq = srwd_pkg::SeqW'(WINDOW);

   // ---------------------------------------------------------------- storage
   // Each entry holds {newest sequence, history}; undefined until written.
   logic [EW-1:0]    win_mem [DEPTH];
   logic [EW-1:0]    rd_data_ff;
   logic [DEPTH-1:0] seen_ff;

   // ------------------------------------------------------------- handshake
   logic              req_fire;
   logic              s1_fire;
   logic              s1_valid_ff, s1_valid_in;
   srwd_pkg::req_type s1_req_ff;
   logic              fwd_hit_ff, fwd_hit_in;
   logic [EW-1:0]     fwd_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   srwd_pkg::rsp_type rsp_data_ff, rsp_data_in;

   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_fire);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && !rsp_ready);

   // ---------------------------------------------------------- update stage
   logic [AW-1:0]              s1_idx;
   logic                       s1_in_range;
   logic                       s1_is_recv;
   logic                       s1_write;
   logic [EW-1:0]              cur_entry;
   logic [srwd_pkg::SeqW-1:0]  cur_seq;
   logic [WINDOW-1:0]          cur_hist;
   logic                       cur_seen;
   logic [srwd_pkg::SeqW-1:0]  dist_fwd;
   logic [srwd_pkg::SeqW-1:0]  dist_back;
   logic [srwd_pkg::SeqW-1:0]  back_m1;
   logic                       ahead;
   logic                       hist_hit;
   logic [srwd_pkg::SeqW-1:0]  new_seq;
   logic [WINDOW-1:0]          new_hist;
   logic [srwd_pkg::VerdictW-1:0] verdict;
   logic                       new_seen;
   logic [63:0]                hist_wide;

   assign s1_idx      = s1_req_ff.peer[AW-1:0];
   assign s1_in_range = int'(s1_req_ff.peer) < PEERS;
   assign s1_is_recv  = s1_req_ff.kind == srwd_pkg::KIND_RECV;
   assign s1_write    = s1_fire && s1_in_range && s1_is_recv;

   // Take the entry just written by the previous transaction if it matched.
   assign cur_entry = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
   assign cur_seq   = cur_entry[EW-1:WINDOW];
   assign cur_hist  = cur_entry[WINDOW-1:0];
   assign cur_seen  = s1_in_range && seen_ff[s1_idx];

   // Serial arithmetic: newer means a forward distance in 1..32767.
   assign dist_fwd  = s1_req_ff.seq - cur_seq;
   assign dist_back = cur_seq - s1_req_ff.seq;
   assign back_m1   = dist_back - srwd_pkg::SeqW'(1);
   assign ahead     = (dist_fwd != '0) && !dist_fwd[srwd_pkg::SeqW-1];
   assign hist_hit  = (dist_back != '0) && (dist_back <= WinSeq) &&
                      ((cur_hist >> back_m1[SW-1:0]) & WINDOW'(1)) != '0;

   always_comb begin
      new_seq  = cur_seq;
      new_hist = cur_hist;
      verdict  = srwd_pkg::VERDICT_ACCEPT;
      if (s1_in_range && s1_is_recv) begin
         if (!cur_seen) begin
            // first packet from this peer: start a fresh window
            new_seq  = s1_req_ff.seq;
            new_hist = '0;
         end else if (ahead) begin
            new_seq = s1_req_ff.seq;
            if (dist_fwd >= WinSeq) begin
               new_hist = '0;
            end else begin
               new_hist = (cur_hist << dist_fwd[SW-1:0]) |
                          (WINDOW'(1) << (dist_fwd[SW-1:0] - SW'(1)));
            end
         end else if (dist_back == '0 || hist_hit) begin
            verdict = srwd_pkg::VERDICT_DUP;
         end else if (dist_back > WinSeq) begin
            verdict = srwd_pkg::VERDICT_TOO_OLD;
         end else begin
            new_hist = cur_hist | (WINDOW'(1) << back_m1[SW-1:0]);
         end
      end
   end

   assign new_seen  = cur_seen || (s1_in_range && s1_is_recv);
   assign hist_wide = 64'(new_hist);

   always_comb begin
      rsp_data_in.verdict     = verdict;
      rsp_data_in.ack_valid   = new_seen;
      rsp_data_in.ack_seq     = new_seen ? new_seq : '0;
      rsp_data_in.ack_history = new_seen ? hist_wide[srwd_pkg::HistOutW-1:0] : '0;
   end

   // Forward when the incoming request reads the entry written this cycle.
   assign fwd_hit_in = s1_write && (req_data.peer[AW-1:0] == s1_idx);

   // ---------------------------------------------------------------- memory
   always_ff @(posedge clock) begin
      if (s1_write) begin
         win_mem[s1_idx] <= {new_seq, new_hist};
      end
      if (req_fire) begin
         rd_data_ff <= win_mem[req_data.peer[AW-1:0]];
      end
   end

   // ------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         seen_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // Drop the forward flag once its transaction leaves the stage.
         if (req_fire) begin
            fwd_hit_ff <= fwd_hit_in;
         end else if (s1_fire) begin
            fwd_hit_ff <= 1'b0;
         end
         if (s1_write) begin
            seen_ff[s1_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff   <= req_data;
         fwd_data_ff <= {new_seq, new_hist};
      end
      if (s1_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------ assertions
   logic rsp_no_ack;
   logic rsp_ack_zero;
   logic rsp_code_ok;
   logic rsp_stalled;

   assign rsp_no_ack   = rsp_valid_ff && !rsp_data_ff.ack_valid;
   assign rsp_ack_zero = rsp_data_ff.ack_seq == '0 && rsp_data_ff.ack_history == '0;
   assign rsp_code_ok  = rsp_data_ff.verdict != srwd_pkg::VERDICT_UNUSED;
   assign rsp_stalled  = s1_valid_ff && rsp_valid_ff && !rsp_ready;

`include "seq_receive_window_dedup_assert.svh"

   `SRWD_ASSERT_NOW(a_no_ack_zero, clock, reset, rsp_no_ack, rsp_ack_zero)
   `SRWD_ASSERT_NOW(a_verdict_code, clock, reset, rsp_valid_ff, rsp_code_ok)
   `SRWD_ASSERT_NOW(a_ready_low_stall, clock, reset, !req_ready, rsp_stalled)
   `SRWD_ASSERT_NEXT(a_fire_to_rsp, clock, reset, s1_fire, rsp_valid_ff)
   `SRWD_ASSERT_NOW(a_fwd_needs_stage, clock, reset, fwd_hit_ff, s1_valid_ff)

endmodule
